FILE: rtl/rgrs_pkg.sv
// Package for the rotating-groups range-sum block.
// Holds widths, the opcode type and the memory request struct. No dependencies.
package rgrs_pkg;

    localparam int MAX_STATIONS = 1024;
    localparam int ADDR_W       = $clog2(MAX_STATIONS);
    localparam int NUM_W        = $clog2(MAX_STATIONS + 1);
    localparam int LINE_W       = 11;
    localparam int CNT_W        = 16;
    localparam int TOT_W        = 26;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_SURVEY = 2'd1,
        OP_ROTATE = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef struct packed {
        logic              we_line;
        logic              we_cnt;
        logic [ADDR_W-1:0] waddr;
        logic [LINE_W-1:0] wline;
        logic [CNT_W-1:0]  wcnt;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

endpackage

FILE: rtl/rgrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rgrs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/rgrs_core.sv
// Sequencer and shared compare/add datapath for the range-sum block.
// Depends on rgrs_pkg; drives the station line and count RAMs.
module rgrs_core
    import rgrs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        opcode,
    input  logic [LINE_W-1:0] line_id,
    input  logic [CNT_W-1:0]  count_value,
    input  logic [10:0]       range_low,
    input  logic [10:0]       range_high,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [TOT_W-1:0]  survey_total,
    output mem_req_t          mem_req,
    input  logic [LINE_W-1:0] rd_line,
    input  logic [CNT_W-1:0]  rd_cnt
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SWAP,
        S_SUM,
        S_PUSH
    } state_t;

    state_t            state_reg;
    logic [NUM_W-1:0]  ld_reg;
    logic [NUM_W-1:0]  idx_reg;
    logic [NUM_W-1:0]  end_reg;
    logic              pend_reg;
    logic [ADDR_W-1:0] paddr_reg;
    logic [LINE_W-1:0] line_reg;
    logic [CNT_W-1:0]  carry_reg;
    logic              found_reg;
    logic [TOT_W-1:0]  sum_reg;
    logic              out_valid_reg;
    logic [TOT_W-1:0]  total_reg;

    logic              accept;
    logic              issue;
    logic              match;
    logic              out_load;
    logic [TOT_W:0]    sum_wide;
    logic [NUM_W-1:0]  lo_clip;
    logic [NUM_W-1:0]  hi_clip;
    opcode_t           op;

    assign op       = opcode_t'(opcode);
    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign issue    = (idx_reg < end_reg);
    assign match    = pend_reg && (rd_line == line_reg);
    assign sum_wide = {1'b0, sum_reg} + {{(TOT_W + 1 - CNT_W){1'b0}}, rd_cnt};
    assign lo_clip  = (range_low == '0) ? NUM_W'(1) : NUM_W'(range_low);
    assign hi_clip  = (NUM_W'(range_high) > ld_reg) ? ld_reg : NUM_W'(range_high);
    // result register free, or its word leaves this cycle
    assign out_load = (state_reg == S_PUSH) && (!out_valid_reg || !out_stall);

    // memory port: loads in idle, count write-back while swapping
    always_comb
    begin
        mem_req.raddr   = idx_reg[ADDR_W-1:0];
        mem_req.wline   = line_id;
        mem_req.we_line = 1'b0;
        mem_req.we_cnt  = 1'b0;
        mem_req.waddr   = ld_reg[ADDR_W-1:0];
        mem_req.wcnt    = count_value;
        if (state_reg == S_SWAP)
        begin
            mem_req.waddr  = paddr_reg;
            mem_req.wcnt   = carry_reg;
            mem_req.we_cnt = match;
        end
        else if (accept && op == OP_LOAD && ld_reg < NUM_W'(MAX_STATIONS))
        begin
            mem_req.we_line = 1'b1;
            mem_req.we_cnt  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ld_reg        <= '0;
            idx_reg       <= '0;
            end_reg       <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg != S_IDLE && state_reg != S_PUSH)
            begin
                pend_reg  <= issue;
                paddr_reg <= idx_reg[ADDR_W-1:0];
                if (issue)
                begin
                    idx_reg <= idx_reg + NUM_W'(1);
                end
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (op)
                            OP_LOAD:
                            begin
                                if (ld_reg < NUM_W'(MAX_STATIONS))
                                begin
                                    ld_reg <= ld_reg + NUM_W'(1);
                                end
                            end
                            OP_SURVEY:
                            begin
                                idx_reg   <= lo_clip - NUM_W'(1);
                                end_reg   <= hi_clip;
                                sum_reg   <= '0;
                                state_reg <= S_SUM;
                            end
                            OP_ROTATE:
                            begin
                                idx_reg   <= '0;
                                end_reg   <= ld_reg;
                                line_reg  <= line_id;
                                found_reg <= 1'b0;
                                state_reg <= S_SCAN;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    // last matching station's count seeds the carry
                    if (match)
                    begin
                        carry_reg <= rd_cnt;
                        found_reg <= 1'b1;
                    end
                    if (!issue && !pend_reg)
                    begin
                        idx_reg   <= '0;
                        state_reg <= found_reg ? S_SWAP : S_IDLE;
                    end
                end
                S_SWAP:
                begin
                    if (match)
                    begin
                        carry_reg <= rd_cnt;
                    end
                    if (!issue && !pend_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_SUM:
                begin
                    if (pend_reg)
                    begin
                        sum_reg <= sum_wide[TOT_W] ? '1 : sum_wide[TOT_W-1:0];
                    end
                    if (!issue && !pend_reg)
                    begin
                        state_reg <= S_PUSH;
                    end
                end
                S_PUSH:
                begin
                    if (out_load)
                    begin
                        total_reg <= sum_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign survey_total = total_reg;

endmodule

FILE: rtl/rotating_groups_range_sum_top.sv
// Operation: a load writes one station; a survey reads each station in range and may
// wait on out_stall while the previous result word is held; a rotate makes a scan pass
// over the loaded stations and, when the line has a station, a swap pass as well.
// The single RAM read port reads one station per cycle in each pass.
// Throughput: one word at a time; in_stall is high until the current word is done.
// Reset: rst_n async low clears the station count, sequencer and output valid;
// RAM contents are not cleared and are only read below the loaded count.
// Top level: station line/count RAMs plus the sequencer. Depends on rgrs_pkg,
// rgrs_ram and rgrs_core.
module rotating_groups_range_sum_top
    import rgrs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        opcode,
    input  logic [LINE_W-1:0] line_id,
    input  logic [CNT_W-1:0]  count_value,
    input  logic [10:0]       range_low,
    input  logic [10:0]       range_high,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [TOT_W-1:0]  survey_total
);

    mem_req_t          mem_req;
    logic [LINE_W-1:0] rd_line;
    logic [CNT_W-1:0]  rd_cnt;

    // station s lives at address s-1 in both RAMs
    rgrs_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_STATIONS)
    ) u_line_ram (
        .clk   (clk),
        .we    (mem_req.we_line),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wline),
        .raddr (mem_req.raddr),
        .rdata (rd_line)
    );

    rgrs_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_STATIONS)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (mem_req.we_cnt),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wcnt),
        .raddr (mem_req.raddr),
        .rdata (rd_cnt)
    );

    // sequencer: loads, scan/swap passes for rotate, accumulate for survey
    rgrs_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .line_id      (line_id),
        .count_value  (count_value),
        .range_low    (range_low),
        .range_high   (range_high),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .survey_total (survey_total),
        .mem_req      (mem_req),
        .rd_line      (rd_line),
        .rd_cnt       (rd_cnt)
    );

endmodule

FILE: rtl/rgrs_checker.sv
// Port-level checks for the range-sum block, bound to the top level.
// Depends on rgrs_pkg.
module rgrs_checker
    import rgrs_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic [1:0]       opcode,
    input logic             out_valid,
    input logic             out_stall,
    input logic [TOT_W-1:0] survey_total
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(survey_total))
        else $error("stalled result word changed");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (opcode == OP_SURVEY || opcode == OP_ROTATE)
        |=> in_stall)
        else $error("survey or rotate not held busy");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && opcode == OP_LOAD |=> !in_stall)
        else $error("load did not complete in one cycle");

    a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result word without survey in progress");

endmodule

bind rotating_groups_range_sum_top rgrs_checker u_rgrs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .survey_total (survey_total)
);
